// ===== hw/rtl/tbrl_pkg.sv =====
package tbrl_pkg;

  localparam int unsigned OP_W         = 2;
  localparam int unsigned TIME_W       = 64;
  localparam int unsigned COST_W       = 16;
  localparam int unsigned RATE_W       = 20;
  localparam int unsigned TOKEN_SCALE  = 1000000;
  localparam int unsigned NEED_W       = COST_W + $clog2(TOKEN_SCALE);
  localparam int unsigned BURST_TOKENS_DEF = 16;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(10);

  typedef enum logic [OP_W-1:0] {
    OP_CONSUME = 2'd0,
    OP_QUERY   = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

endpackage

// ===== hw/rtl/tbrl_in_if.sv =====
interface tbrl_in_if;
  logic                             valid;
  logic                             ready;
  logic [tbrl_pkg::OP_W-1:0]        operation;
  logic [tbrl_pkg::TIME_W-1:0]      now_us;
  logic [tbrl_pkg::COST_W-1:0]      cost;

  modport source (output valid, output operation, output now_us, output cost, input ready);
  modport sink (input valid, input operation, input now_us, input cost, output ready);
endinterface

// ===== hw/rtl/tbrl_out_if.sv =====
interface tbrl_out_if;
  logic                             valid;
  logic                             ready;
  logic                             granted;
  logic [tbrl_pkg::TIME_W-1:0]      deadline_us;

  modport source (output valid, output granted, output deadline_us, input ready);
  modport sink (input valid, input granted, input deadline_us, output ready);
endinterface

// ===== hw/rtl/token_bucket_rate_limiter.sv =====
// channel   dir  signals                                      transfer
// in_i      in   valid ready operation now_us cost            valid && ready
// out_o     out  valid ready granted deadline_us              valid && ready
// cfg       in   cfg_we_i cfg_data_i (rate_per_second)        cfg_we_i
//
// one item at a time: a restart needs no arithmetic, a covered consume or query
// waits for the bit-serial refill multiply, an uncovered one also for the
// bit-serial ceiling division of the missing units by the rate.
// the result sits in an output register; the next item is taken while it waits.
// reset fills the bucket, clears the refill time and sets the rate to 10.
module token_bucket_rate_limiter #(
  parameter int unsigned BURST_TOKENS = tbrl_pkg::BURST_TOKENS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tbrl_pkg::RATE_W-1:0] cfg_data_i,
  tbrl_in_if.sink                     in_i,
  tbrl_out_if.source                  out_o
);

  localparam int unsigned CAP_UNITS = BURST_TOKENS * tbrl_pkg::TOKEN_SCALE;
  localparam int unsigned BW        = $clog2(CAP_UNITS + 1);
  localparam int unsigned TW        = tbrl_pkg::TIME_W;
  localparam int unsigned RW        = tbrl_pkg::RATE_W;
  localparam int unsigned NW        = tbrl_pkg::NEED_W;
  localparam int unsigned CW        = tbrl_pkg::COST_W;
  localparam int unsigned PW        = BW + RW;
  localparam logic [BW-1:0] CAP     = BW'(CAP_UNITS);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL   = 5'b00010,
    S_AVAIL = 5'b00100,
    S_CHK   = 5'b01000,
    S_DIV   = 5'b10000
  } state_e;

  state_e                    state_q, state_d;
  logic                      done_q, done_d;
  logic [RW-1:0]             rate_q;
  logic [BW-1:0]             bucket_q;
  logic [TW-1:0]             last_q;
  logic [tbrl_pkg::OP_W-1:0] op_q;
  logic [TW-1:0]             now_q;
  logic [CW-1:0]             cost_q;
  logic [NW-1:0]             need_q;
  logic                      big_q;
  logic [BW-1:0]             avail_q;
  logic                      covered_q;
  logic [TW-1:0]             deadline_q;
  logic                      out_valid_q;
  logic                      out_granted_q;
  logic [TW-1:0]             out_deadline_q;

  logic [RW-1:0]             rate_eff;
  logic                      in_xfer;
  logic                      in_restart;
  logic [TW-1:0]             elapsed;
  logic                      mul_start;
  logic                      mul_done;
  logic [PW-1:0]             mul_p;
  logic [BW-1:0]             room;
  logic                      full;
  logic                      covered;
  logic                      div_start;
  logic                      div_done;
  logic [NW-1:0]             div_q;
  logic                      div_rnz;
  logic                      cost_ok;
  logic                      is_restart;
  logic                      is_consume;
  logic                      out_free;

  assign rate_eff   = (rate_q == '0) ? RW'(1) : rate_q;
  assign in_xfer    = in_i.valid && in_i.ready;
  assign in_restart = in_i.operation == tbrl_pkg::OP_RESTART;
  assign elapsed    = in_i.now_us - last_q;
  assign mul_start  = in_xfer && !in_restart;
  assign room       = CAP - bucket_q;
  assign full       = big_q || (mul_p >= PW'(room));
  assign covered    = NW'(avail_q) >= need_q;
  assign div_start  = (state_q == S_CHK) && !covered;
  assign cost_ok    = (cost_q != '0) && (cost_q <= CW'(BURST_TOKENS));
  assign is_restart = op_q == tbrl_pkg::OP_RESTART;
  assign is_consume = op_q == tbrl_pkg::OP_CONSUME;
  assign out_free   = !out_valid_q || out_o.ready;

  assign in_i.ready        = (state_q == S_IDLE) && !done_q;
  assign out_o.valid       = out_valid_q;
  assign out_o.granted     = out_granted_q;
  assign out_o.deadline_us = out_deadline_q;

  tbrl_mul #(
    .AW (BW),
    .RW (RW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (elapsed[BW-1:0]),
    .b_i     (rate_eff),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  tbrl_div #(
    .DW (NW),
    .RW (RW)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .n_i      (need_q - NW'(avail_q)),
    .d_i      (rate_eff),
    .done_o   (div_done),
    .q_o      (div_q),
    .rem_nz_o (div_rnz)
  );

  always_comb begin
    state_d = state_q;
    done_d  = done_q;
    case (state_q)
      S_IDLE: begin
        if (done_q) begin
          if (out_free) begin
            done_d = 1'b0;
          end
        end else if (in_xfer) begin
          if (in_restart) begin
            done_d = 1'b1;
          end else begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (mul_done) begin
          state_d = S_AVAIL;
        end
      end
      S_AVAIL: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        if (covered) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
        done_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      done_q      <= 1'b0;
      rate_q      <= tbrl_pkg::RATE_RESET;
      bucket_q    <= CAP;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        rate_q <= cfg_data_i;
      end
      if (done_q && out_free) begin
        out_valid_q <= 1'b1;
        if (is_restart) begin
          bucket_q <= CAP;
          last_q   <= now_q;
        end else if (is_consume && cost_ok) begin
          bucket_q <= covered_q ? avail_q - BW'(need_q) : avail_q;
          last_q   <= now_q;
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q       <= in_i.operation;
      now_q      <= in_i.now_us;
      cost_q     <= in_i.cost;
      need_q     <= NW'(in_i.cost) * NW'(tbrl_pkg::TOKEN_SCALE);
      big_q      <= |elapsed[TW-1:BW];
      deadline_q <= in_i.now_us;
    end
    if (state_q == S_AVAIL) begin
      avail_q <= full ? CAP : bucket_q + mul_p[BW-1:0];
    end
    if (state_q == S_CHK) begin
      covered_q <= covered;
    end
    if (div_done) begin
      deadline_q <= now_q + TW'(div_q) + TW'(div_rnz);
    end
    if (done_q && out_free) begin
      out_granted_q  <= is_restart || (cost_ok && covered_q);
      out_deadline_q <= deadline_q;
    end
  end

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_bucket_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bucket_q <= CAP)
    else $error("bucket above capacity");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(done_q))
    else $error("result shown without a finished item");

  a_restart_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_restart) |=> (done_q && state_q == S_IDLE))
    else $error("restart did not finish in one cycle");

endmodule

// ===== hw/rtl/tbrl_mul.sv =====
module tbrl_mul #(
  parameter int unsigned AW = 24,
  parameter int unsigned RW = tbrl_pkg::RATE_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AW-1:0]    a_i,
  input  logic [RW-1:0]    b_i,
  output logic             done_o,
  output logic [AW+RW-1:0] p_o
);

  localparam int unsigned CW = $clog2(RW + 1);

  logic [AW-1:0]    a_q;
  logic [RW-1:0]    b_q;
  logic [AW+RW-1:0] p_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;

  // one multiplier bit per cycle, msb first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(RW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      p_q <= '0;
    end else if (busy_q) begin
      p_q <= {p_q[AW+RW-2:0], 1'b0} + (b_q[RW-1] ? (AW+RW)'(a_q) : '0);
      b_q <= {b_q[RW-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

// ===== hw/rtl/tbrl_div.sv =====
module tbrl_div #(
  parameter int unsigned DW = tbrl_pkg::NEED_W,
  parameter int unsigned RW = tbrl_pkg::RATE_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] n_i,
  input  logic [RW-1:0] d_i,
  output logic          done_o,
  output logic [DW-1:0] q_o,
  output logic          rem_nz_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] q_q;
  logic [RW-1:0] r_q;
  logic [RW-1:0] d_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [RW:0]   trial;
  logic          ge;
  logic [RW:0]   diff;

  // restoring division, one quotient bit per cycle
  assign trial = {r_q, q_q[DW-1]};
  assign ge    = trial >= {1'b0, d_q};
  assign diff  = trial - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= n_i;
      r_q <= '0;
      d_q <= d_i;
    end else if (busy_q) begin
      q_q <= {q_q[DW-2:0], ge};
      r_q <= ge ? diff[RW-1:0] : trial[RW-1:0];
    end
  end

  assign done_o   = done_q;
  assign q_o      = q_q;
  assign rem_nz_o = |r_q;

endmodule

// ===== bench/tb_token_bucket_rate_limiter.sv =====
`timescale 1ns / 1ps

module tb_token_bucket_rate_limiter;
  import tbrl_pkg::*;

  localparam int unsigned BURST = BURST_TOKENS_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [TIME_W-1:0] CAPACITY = 64'(BURST) * 64'(TOKEN_SCALE);
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam int unsigned MAX_SHOWN = 10;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned PHASE_ITEMS = 200;

  typedef struct packed {
    logic              granted;
    logic [TIME_W-1:0] deadline_us;
  } verdict_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [RATE_W-1:0] cfg_data_i;

  tbrl_in_if  in_if ();
  tbrl_out_if out_if ();

  token_bucket_rate_limiter #(
    .BURST_TOKENS(BURST)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [RATE_W-1:0] model_rate;
  logic [TIME_W-1:0] model_units;
  logic [TIME_W-1:0] model_stamp;
  logic [TIME_W-1:0] stamp_cursor;
  verdict_t          pending_verdicts[$];
  int unsigned       mismatch_count;
  int unsigned       checked_count;
  int unsigned       rate_writes;
  int unsigned       op_count[4];
  int unsigned       stall_left;
  bit                steady_flow;

  function automatic logic [TIME_W-1:0] active_rate();
    return (model_rate == '0) ? 64'd1 : 64'(model_rate);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady_flow) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic verdict_t advance_bucket(logic [OP_W-1:0] op, logic [TIME_W-1:0] now,
                                              logic [COST_W-1:0] cost);
    logic [TIME_W-1:0] r;
    logic [TIME_W-1:0] room;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] avail;
    logic [TIME_W-1:0] need;
    logic              cost_ok;
    verdict_t          v;
    r = active_rate();
    need = 64'(cost) * 64'(TOKEN_SCALE);
    cost_ok = (cost != '0) && (cost <= BURST);
    if (op == OP_RESTART) begin
      model_units = CAPACITY;
      model_stamp = now;
      v.granted = 1'b1;
      v.deadline_us = now;
      return v;
    end
    room = (model_units < CAPACITY) ? CAPACITY - model_units : '0;
    elapsed = now - model_stamp;
    avail = (elapsed >= (room + r - 1) / r) ? CAPACITY : model_units + elapsed * r;
    v.deadline_us = (avail >= need) ? now : now + (need - avail + r - 1) / r;
    v.granted = 1'b0;
    if (op == OP_CONSUME) begin
      if (cost_ok) begin
        model_stamp = now;
        model_units = avail;
        if (avail >= need) begin
          model_units = avail - need;
          v.granted = 1'b1;
        end
      end
    end else begin
      v.granted = cost_ok && (avail >= need);
    end
    return v;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk_i) begin : result_check
    verdict_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      checked_count++;
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: granted=%0b deadline=%0h",
                                  out_if.granted, out_if.deadline_us));
      end else begin
        want = pending_verdicts.pop_front();
        if (out_if.granted !== want.granted || out_if.deadline_us !== want.deadline_us)
          report_mismatch($sformatf(
            "expected granted=%0b deadline=%0h, got granted=%0b deadline=%0h",
            want.granted, want.deadline_us, out_if.granted, out_if.deadline_us));
      end
    end
    if (steady_flow) begin
      out_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  task automatic send_request(logic [OP_W-1:0] op, logic [TIME_W-1:0] now,
                              logic [COST_W-1:0] cost);
    int unsigned gap;
    gap = pick_gap();
    pending_verdicts.push_back(advance_bucket(op, now, cost));
    op_count[op]++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.now_us    <= now;
    in_if.cost      <= cost;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_rate(logic [RATE_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    model_rate = value;
    rate_writes++;
  endtask

  task automatic send_random_request();
    logic [OP_W-1:0]   op;
    logic [COST_W-1:0] cost;
    logic [TIME_W-1:0] tick;
    int unsigned       roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) op = OP_CONSUME;
    else if (roll < 85) op = OP_QUERY;
    else if (roll < 93) op = OP_RESTART;
    else op = OP_UNUSED;
    roll = $urandom_range(0, 99);
    if (roll < 60) cost = COST_W'($urandom_range(1, 3));
    else if (roll < 80) cost = COST_W'($urandom_range(1, BURST));
    else if (roll < 85) cost = '0;
    else if (roll < 90) cost = COST_W'($urandom_range(BURST + 1, BURST + 8));
    else if (roll < 94) cost = '1;
    else cost = COST_W'($urandom);
    // one token's worth of refill time in microseconds
    tick = 64'(TOKEN_SCALE) / active_rate();
    if (tick == '0) tick = 64'd1;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      stamp_cursor = stamp_cursor;
    end else if (roll < 75) begin
      stamp_cursor += 64'($urandom_range(0, 32'(3 * tick)));
    end else if (roll < 87) begin
      stamp_cursor += 64'($urandom_range(0, 32'(20 * tick)));
    end else if (roll < 92) begin
      stamp_cursor -= 64'($urandom_range(1, 32'(4 * tick)));
    end else if (roll < 96) begin
      stamp_cursor = {$urandom, $urandom};
    end else begin
      stamp_cursor = TIME_MAX - 64'($urandom_range(0, 32'(4 * tick)));
    end
    send_request(op, stamp_cursor, cost);
  endtask

  task automatic test_directed_cases();
    send_request(OP_CONSUME, 64'd0, COST_W'(BURST));
    send_request(OP_CONSUME, 64'd0, 16'd1);
    send_request(OP_QUERY, 64'd0, COST_W'(BURST));
    send_request(OP_QUERY, 64'd150000, 16'd1);
    send_request(OP_CONSUME, 64'd150000, 16'd0);
    send_request(OP_CONSUME, 64'd150000, COST_W'(BURST + 1));
    send_request(OP_QUERY, 64'd150000, 16'hFFFF);
    send_request(OP_UNUSED, 64'd250000, 16'd2);
    send_request(OP_CONSUME, 64'd250000, 16'd2);
    send_request(OP_RESTART, TIME_MAX, 16'd0);
    send_request(OP_CONSUME, TIME_MAX, COST_W'(BURST));
    // deadline wraps past zero
    send_request(OP_QUERY, TIME_MAX, COST_W'(BURST));
    send_request(OP_CONSUME, 64'd3, 16'd1);
    // time running backwards
    send_request(OP_CONSUME, 64'd1, 16'd1);
    send_request(OP_RESTART, 64'h5555_5555_5555_5555, 16'hAAAA);
    send_request(OP_QUERY, 64'hAAAA_AAAA_AAAA_AAAA, 16'h5555);
  endtask

  task automatic test_rate_extremes();
    wait_idle();
    write_rate('0);
    send_request(OP_CONSUME, 64'd1000, COST_W'(BURST));
    send_request(OP_QUERY, 64'd1000, 16'd1);
    send_request(OP_QUERY, 64'd1001, 16'd1);
    wait_idle();
    write_rate('1);
    send_request(OP_CONSUME, 64'd2000, COST_W'(BURST));
    send_request(OP_QUERY, 64'd2001, 16'd1);
    send_request(OP_QUERY, 64'd2001, COST_W'(BURST));
    wait_idle();
    write_rate(RATE_W'(1));
    send_request(OP_QUERY, 64'd2002, 16'd1);
    stamp_cursor = 64'd2002;
  endtask

  task automatic test_random_traffic(logic [RATE_W-1:0] rate, int unsigned count);
    wait_idle();
    write_rate(rate);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 50 == 0) steady_flow = ($urandom_range(0, 3) == 0);
      send_random_request();
    end
    steady_flow = 1'b0;
  endtask

  initial begin : stimulus
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_data_i      = '0;
    in_if.valid     = 1'b0;
    in_if.operation = OP_CONSUME;
    in_if.now_us    = '0;
    in_if.cost      = '0;
    out_if.ready    = 1'b0;
    steady_flow     = 1'b0;
    stall_left      = 0;
    model_rate      = RATE_RESET;
    model_units     = CAPACITY;
    model_stamp     = '0;
    stamp_cursor    = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_rate_extremes();
    test_random_traffic(RATE_RESET, PHASE_ITEMS);
    test_random_traffic(RATE_W'(1), PHASE_ITEMS);
    test_random_traffic('0, PHASE_ITEMS);
    test_random_traffic(RATE_W'(1000000), PHASE_ITEMS);
    test_random_traffic('1, PHASE_ITEMS);
    test_random_traffic(RATE_W'($urandom_range(2, 1000)), PHASE_ITEMS / 2);
    test_random_traffic(RATE_W'($urandom_range(1001, 1048575)), PHASE_ITEMS / 2);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered consume=%0d query=%0d restart=%0d unused-op=%0d transfers over %0d rate writes",
             op_count[OP_CONSUME], op_count[OP_QUERY], op_count[OP_RESTART],
             op_count[OP_UNUSED], rate_writes);
    $display("%0d results checked, %0d mismatches", checked_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("timeout with %0d results still pending", pending_verdicts.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== token_bucket_rate_limiter.f =====
hw/rtl/tbrl_pkg.sv
hw/rtl/tbrl_in_if.sv
hw/rtl/tbrl_out_if.sv
hw/rtl/tbrl_mul.sv
hw/rtl/tbrl_div.sv
hw/rtl/token_bucket_rate_limiter.sv
bench/tb_token_bucket_rate_limiter.sv
